FILE: sv/kmer_counter_n_filter_assert.svh
// ============================================================================
// kmer counter assertion macros
// Shared concurrent assertion forms for the k-mer counter RTL.
// ============================================================================
`ifndef KMER_COUNTER_N_FILTER_ASSERT_SVH
`define KMER_COUNTER_N_FILTER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define KCF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kcf assertion failed");

// next-cycle implication
`define KCF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kcf assertion failed");

`else

`define KCF_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define KCF_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/kcf_pkg.sv
// ============================================================================
// kcf_pkg
// Types, constants and helper functions of the k-mer counter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kcf_pkg;

    // sizing
    localparam int MAX_KMER    = 8;
    localparam int COUNT_BITS  = 32;
    localparam int CODE_W      = 2 * MAX_KMER;
    localparam int ADDR_W      = CODE_W;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int LEN_W       = $clog2(MAX_KMER + 1);
    localparam int TOTAL_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 2;
    localparam int BASE_W      = 3;
    localparam int QIDX_W      = 16;
    localparam int KLEN_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_STRANDS = 1'b1;

    // reset values of configuration
    localparam logic [KLEN_W-1:0] KMER_LENGTH_RST = 4'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_BASE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_INC   = 2'd1,
        OP_QUERY = 2'd2
    } t_op_kind;

    // one memory operation with the result fields it carries
    typedef struct packed {
        t_op_kind           op;
        logic [ADDR_W-1:0]  addr;
        logic               last;
        logic               counted;
        logic [CODE_W-1:0]  kmer_code;
        logic [TOTAL_W-1:0] total;
    } t_op;

    typedef struct packed {
        logic               counted;
        logic [CODE_W-1:0]  kmer_code;
        logic [TOTAL_W-1:0] total_windows;
        logic [VALUE_W-1:0] count_value;
    } t_result;

    // status from the update stage to the sequencer
    typedef struct packed {
        logic clr_busy;
        logic s1_last;
    } t_rmw_stat;

    // clamp the configured length into 1..MAX_KMER
    function automatic logic [LEN_W-1:0] eff_len(input logic [KLEN_W-1:0] len);
        logic [LEN_W-1:0] k;
        if (len == '0) begin
            k = LEN_W'(1);
        end else if (32'(len) > MAX_KMER) begin
            k = LEN_W'(MAX_KMER);
        end else begin
            k = LEN_W'(len);
        end
        return k;
    endfunction

    // mask that keeps the low k bases
    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] k);
        logic [CODE_W-1:0] m;
        m = ~({CODE_W{1'b1}} << {k, 1'b0});
        return m;
    endfunction

    // reverse complement of the low k bases of a window
    function automatic logic [CODE_W-1:0] rev_comp(input logic [CODE_W-1:0] code,
                                                   input logic [LEN_W-1:0]  k);
        logic [CODE_W-1:0] full;
        logic [LEN_W-1:0]  sh;
        for (int i = 0; i < MAX_KMER; i++) begin
            full[2*(MAX_KMER-1-i) +: 2] = ~code[2*i +: 2];
        end
        sh = LEN_W'(MAX_KMER) - k;
        return full >> {sh, 1'b0};
    endfunction

    // saturating add of a small increment to the window total
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
                                                   input logic [1:0]         inc);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + (TOTAL_W + 1)'(inc);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/kcf_if.sv
// ============================================================================
// kcf channel interfaces
// Valid/ready channels for input items and result items.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface kcf_in_if;
    logic                        valid;
    logic                        ready;
    logic [kcf_pkg::KIND_W-1:0]  kind;
    logic [kcf_pkg::BASE_W-1:0]  base;
    logic [kcf_pkg::QIDX_W-1:0]  query_index;

    modport source (output valid, kind, base, query_index, input ready);
    modport sink   (input valid, kind, base, query_index, output ready);
endinterface

interface kcf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         counted;
    logic [kcf_pkg::CODE_W-1:0]   kmer_code;
    logic [kcf_pkg::TOTAL_W-1:0]  total_windows;
    logic [kcf_pkg::VALUE_W-1:0]  count_value;

    modport source (output valid, counted, kmer_code, total_windows, count_value,
                    input ready);
    modport sink   (input valid, counted, kmer_code, total_windows, count_value,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/kcf_ram.sv
// ============================================================================
// kcf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and read port, read returns the old contents on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/kcf_seq.sv
// ============================================================================
// kcf_seq
// Input sequencer: window, run length, total, and memory op issue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_counter_n_filter_assert.svh"

module kcf_seq (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    kcf_in_if.sink                                i_kmer,
    input  wire logic                             i_cfg_we,
    input  wire logic [kcf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [kcf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire kcf_pkg::t_rmw_stat               i_stat,
    input  wire logic [kcf_pkg::CNT_W-1:0]        i_fifo_count,
    output logic                                  o_issue_valid,
    output kcf_pkg::t_op                          o_issue_op
);

    localparam int CW = kcf_pkg::CODE_W;
    localparam int LW = kcf_pkg::LEN_W;

    logic [kcf_pkg::KLEN_W-1:0]  r_kmer_len;
    logic                        r_both;
    logic [CW-1:0]               r_win;
    logic [LW-1:0]               r_run;
    logic [kcf_pkg::TOTAL_W-1:0] r_total;
    logic                        r_pend_valid;
    kcf_pkg::t_op                r_pend_op;

    logic [CW-1:0]               n_win;
    logic [LW-1:0]               n_run;
    logic [kcf_pkg::TOTAL_W-1:0] n_total;
    logic                        accept;
    logic                        room;
    logic [LW-1:0]               k;
    logic [LW-1:0]               run_inc;
    logic [CW-1:0]               shifted;
    logic                        hit;
    logic                        dual;
    logic [CW-1:0]               fwd_code;
    logic [CW-1:0]               rc_code;
    kcf_pkg::t_op                acc_op;
    kcf_pkg::t_op                rc_op;

    // accept when not clearing, no second op pending, and a result slot is free
    assign room = ({1'b0, i_fifo_count} + (kcf_pkg::CNT_W + 1)'(i_stat.s1_last))
                  < (kcf_pkg::CNT_W + 1)'(kcf_pkg::FIFO_DEPTH);
    assign i_kmer.ready = !i_stat.clr_busy && !r_pend_valid && room;
    assign accept       = i_kmer.valid && i_kmer.ready;

    // window and run arithmetic for a base
    assign k        = kcf_pkg::eff_len(r_kmer_len);
    assign shifted  = {r_win[CW-3:0], i_kmer.base[1:0]};
    assign run_inc  = (r_run < LW'(kcf_pkg::MAX_KMER)) ? r_run + LW'(1) : r_run;
    assign fwd_code = shifted & kcf_pkg::code_mask(k);
    assign rc_code  = kcf_pkg::rev_comp(shifted, k);

    // item decode
    always_comb begin
        n_win          = r_win;
        n_run          = r_run;
        n_total        = r_total;
        hit            = 1'b0;
        acc_op.op        = kcf_pkg::OP_NOP;
        acc_op.addr      = '0;
        acc_op.last      = 1'b1;
        acc_op.counted   = 1'b0;
        acc_op.kmer_code = '0;
        unique case (kcf_pkg::t_kind'(i_kmer.kind))
            kcf_pkg::KIND_BASE: begin
                if (!i_kmer.base[2]) begin
                    n_win = shifted;
                    n_run = run_inc;
                    hit   = (run_inc >= k);
                end else begin
                    n_run = '0;
                end
            end
            kcf_pkg::KIND_END: begin
                n_win = '0;
                n_run = '0;
            end
            kcf_pkg::KIND_QUERY: begin
                acc_op.op   = kcf_pkg::OP_QUERY;
                acc_op.addr = i_kmer.query_index[kcf_pkg::ADDR_W-1:0];
            end
            kcf_pkg::KIND_NONE: begin
            end
        endcase
        if (hit) begin
            n_total          = kcf_pkg::sat_add(r_total, r_both ? 2'd2 : 2'd1);
            acc_op.op        = kcf_pkg::OP_INC;
            acc_op.addr      = fwd_code;
            acc_op.last      = !r_both;
            acc_op.counted   = 1'b1;
            acc_op.kmer_code = fwd_code;
        end
        acc_op.total = n_total;
    end

    // reverse-complement op, last of its item
    always_comb begin
        rc_op      = acc_op;
        rc_op.addr = rc_code;
        rc_op.last = 1'b1;
    end

    assign dual = hit && r_both;

    // issue to the memory stage
    assign o_issue_valid = accept || r_pend_valid;
    assign o_issue_op    = r_pend_valid ? r_pend_op : acc_op;

    // state, configuration and pending reverse-complement op
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len   <= kcf_pkg::KMER_LENGTH_RST;
            r_both       <= 1'b1;
            r_win        <= '0;
            r_run        <= '0;
            r_total      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kcf_pkg::CFG_KMER_LENGTH:  r_kmer_len <= i_cfg_data;
                    kcf_pkg::CFG_BOTH_STRANDS: r_both     <= i_cfg_data[0];
                endcase
            end
            if (accept) begin
                r_win   <= n_win;
                r_run   <= n_run;
                r_total <= n_total;
            end
            r_pend_valid <= accept && dual;
        end
    end

    // pending op payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_op <= rc_op;
        end
    end

    `KCF_ASSERT_NEXT(a_pend_after_dual, i_clk, i_rst_n, accept && dual, r_pend_valid)
    `KCF_ASSERT_NEXT(a_total_monotonic, i_clk, i_rst_n, accept, r_total >= $past(r_total))
    `KCF_ASSERT_IMPL(a_no_accept_pending, i_clk, i_rst_n, r_pend_valid, !accept)

endmodule

`default_nettype wire

FILE: sv/kcf_rmw.sv
// ============================================================================
// kcf_rmw
// Count memory update stage: forwarding, saturating increment, write-back,
// result formation and the clearing sweep after reset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_counter_n_filter_assert.svh"

module kcf_rmw (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_issue_valid,
    input  wire kcf_pkg::t_op                       i_issue_op,
    input  wire logic [kcf_pkg::COUNT_BITS-1:0]     i_rd_data,
    output logic                                    o_wr_en,
    output logic      [kcf_pkg::ADDR_W-1:0]         o_wr_addr,
    output logic      [kcf_pkg::COUNT_BITS-1:0]     o_wr_data,
    output kcf_pkg::t_rmw_stat                      o_stat,
    output logic                                    o_push,
    output kcf_pkg::t_result                        o_result
);

    localparam int AW = kcf_pkg::ADDR_W;
    localparam int NW = kcf_pkg::COUNT_BITS;

    logic          r_s1_valid;
    kcf_pkg::t_op  r_s1;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [NW-1:0] r_fwd_data;

    logic [NW-1:0] cur;
    logic [NW-1:0] inc_val;
    logic          is_inc;

    // forward the write of the read cycle, the memory returned stale data
    assign cur     = (r_fwd_valid && (r_fwd_addr == r_s1.addr)) ? r_fwd_data : i_rd_data;
    assign inc_val = (cur == {NW{1'b1}}) ? cur : cur + NW'(1);
    assign is_inc  = r_s1_valid && (r_s1.op == kcf_pkg::OP_INC);

    // write port: clearing sweep first, else the increment
    always_comb begin
        if (r_clr_busy) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_clr_addr;
            o_wr_data = '0;
        end else begin
            o_wr_en   = is_inc;
            o_wr_addr = r_s1.addr;
            o_wr_data = inc_val;
        end
    end

    // result of the last op of an item
    assign o_push                 = r_s1_valid && r_s1.last;
    assign o_result.counted       = r_s1.counted;
    assign o_result.kmer_code     = r_s1.kmer_code;
    assign o_result.total_windows = r_s1.total;
    assign o_result.count_value   = (r_s1.op == kcf_pkg::OP_QUERY) ?
                                    kcf_pkg::VALUE_W'(cur) : '0;

    assign o_stat.clr_busy = r_clr_busy;
    assign o_stat.s1_last  = r_s1_valid && r_s1.last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_issue_valid;
            r_fwd_valid <= o_wr_en;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == {AW{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1       <= i_issue_op;
        r_fwd_addr <= o_wr_addr;
        r_fwd_data <= o_wr_data;
    end

    `KCF_ASSERT_IMPL(a_no_issue_in_clear, i_clk, i_rst_n, i_issue_valid, !r_clr_busy)
    `KCF_ASSERT_IMPL(a_no_op_in_clear, i_clk, i_rst_n, r_clr_busy, !r_s1_valid)
    `KCF_ASSERT_NEXT(a_fwd_tracks_write, i_clk, i_rst_n, o_wr_en,
                     r_fwd_valid && (r_fwd_addr == $past(o_wr_addr)))

endmodule

`default_nettype wire

FILE: sv/kcf_fifo.sv
// ============================================================================
// kcf_fifo
// Small result queue that decouples the update stage from the output channel.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_counter_n_filter_assert.svh"

module kcf_fifo (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire kcf_pkg::t_result             i_data,
    kcf_out_if.source                         o_res,
    output logic [kcf_pkg::CNT_W-1:0]         o_count
);

    localparam int PW = kcf_pkg::PTR_W;
    localparam int CW = kcf_pkg::CNT_W;

    kcf_pkg::t_result r_mem [kcf_pkg::FIFO_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             pop;
    kcf_pkg::t_result head;

    assign head                = r_mem[r_rd_ptr];
    assign o_res.valid         = (r_count != '0);
    assign o_res.counted       = head.counted;
    assign o_res.kmer_code     = head.kmer_code;
    assign o_res.total_windows = head.total_windows;
    assign o_res.count_value   = head.count_value;
    assign pop                 = o_res.valid && o_res.ready;
    assign o_count             = r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `KCF_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push,
                     (r_count < CW'(kcf_pkg::FIFO_DEPTH)) || pop)
    `KCF_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1,
                     r_count <= CW'(kcf_pkg::FIFO_DEPTH))

endmodule

`default_nettype wire

FILE: sv/kmer_counter_n_filter.sv
// ============================================================================
// kmer_counter_n_filter
// Streaming k-mer counter with N filtering and optional reverse complement.
// ============================================================================
// Bases enter one per transfer; each base that completes an N-free window of
// kmer_length bases adds one to that k-mer's entry in a 65536 x 32 count
// memory and to a saturating total, and in both-strands mode also to the
// reverse-complement entry and once more to the total. Every input transfer
// gives exactly one result, which passes through the update stage register
// and the result queue. A base that completes a window in both-strands mode
// holds off the next item while its reverse-complement update issues: each
// count update is a read-modify-write on the single write port of the count
// memory. After reset the block sweeps the count memory to zero, one entry a
// cycle, and takes no item until the sweep is done; configuration writes are
// taken at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module kmer_counter_n_filter (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    kcf_in_if.sink                                i_kmer,
    kcf_out_if.source                             o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [kcf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [kcf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                              issue_valid;
    kcf_pkg::t_op                      issue_op;
    kcf_pkg::t_rmw_stat                stat;
    logic [kcf_pkg::CNT_W-1:0]         fifo_count;
    logic [kcf_pkg::COUNT_BITS-1:0]    rd_data;
    logic                              wr_en;
    logic [kcf_pkg::ADDR_W-1:0]        wr_addr;
    logic [kcf_pkg::COUNT_BITS-1:0]    wr_data;
    logic                              push;
    kcf_pkg::t_result                  result;

    // input sequencer
    kcf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kmer       (i_kmer),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_stat       (stat),
        .i_fifo_count (fifo_count),
        .o_issue_valid(issue_valid),
        .o_issue_op   (issue_op)
    );

    // count memory, read at issue
    kcf_ram #(
        .WIDTH(kcf_pkg::COUNT_BITS),
        .DEPTH(kcf_pkg::TABLE_DEPTH)
    ) u_count_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(issue_op.addr),
        .o_rdata(rd_data)
    );

    // update stage
    kcf_rmw u_rmw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue_valid(issue_valid),
        .i_issue_op   (issue_op),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_stat       (stat),
        .o_push       (push),
        .o_result     (result)
    );

    // result queue
    kcf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (result),
        .o_res  (o_res),
        .o_count(fifo_count)
    );

endmodule

`default_nettype wire

FILE: tb/kmer_count_checker.sv
// ============================================================================
// kmer_count_checker
// Watches the base and result channels of the k-mer counter. It keeps its own
// count table, window and total, predicts one result per input transfer, and
// compares each result transfer field by field with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module kmer_count_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kcf_in_if                                i_kmer,
    kcf_out_if                               i_res,
    input  logic                             i_cfg_we,
    input  logic [kcf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kcf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_pending,
    output int                               o_fail_count
);
    import kcf_pkg::*;

    // predicted copy of the block's configuration and state
    logic [KLEN_W-1:0]     kmer_len;
    logic                  both_strands;
    logic [CODE_W-1:0]     window;
    int unsigned           clean_run;
    logic [COUNT_BITS-1:0] tally [TABLE_DEPTH];
    logic [TOTAL_W-1:0]    grand_total;
    t_result               predicted_results [$];
    int                    fails;

    // one saturating count of a k-mer, table entry and total
    function automatic void add_kmer(input logic [CODE_W-1:0] code);
        if (tally[code] != '1) tally[code] = tally[code] + 1'b1;
        if (grand_total != '1) grand_total = grand_total + 1'b1;
    endfunction

    // advance the predicted state by one item and return its result
    function automatic t_result count_item(input t_kind kind,
                                           input logic [BASE_W-1:0] base,
                                           input logic [QIDX_W-1:0] query);
        t_result           r;
        int unsigned       k;
        int                i;
        logic [CODE_W-1:0] fwd;
        logic [CODE_W-1:0] rc;
        r = '0;
        // lengths out of range clamp to 1..MAX_KMER
        if (kmer_len == '0) k = 1;
        else if (int'(kmer_len) > MAX_KMER) k = MAX_KMER;
        else k = kmer_len;
        case (kind)
            KIND_BASE: begin
                if (base < 4) begin
                    window = {window[CODE_W-3:0], base[1:0]};
                    if (clean_run < MAX_KMER) clean_run++;
                    if (clean_run >= k) begin
                        fwd = window & CODE_W'((32'd1 << (2 * k)) - 1);
                        // reverse complement: reversed base order, each base inverted
                        rc = '0;
                        for (i = 0; i < k; i++) rc = {rc[CODE_W-3:0], ~fwd[2*i +: 2]};
                        add_kmer(fwd);
                        if (both_strands) add_kmer(rc);
                        r.counted   = 1'b1;
                        r.kmer_code = fwd;
                    end
                end else begin
                    // any other letter acts as N and restarts the run
                    clean_run = 0;
                end
            end
            KIND_END: begin
                clean_run = 0;
                window    = '0;
            end
            KIND_QUERY: begin
                r.count_value = VALUE_W'(tally[query]);
            end
            default: begin
            end
        endcase
        r.total_windows = grand_total;
        return r;
    endfunction

    // count and report one field mismatch
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            if (fails < 10)
                $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                         $realtime, name, want, got);
            fails++;
        end
    endfunction

    // configuration, result check and prediction at each clock edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            kmer_len     = KMER_LENGTH_RST;
            both_strands = 1'b1;
            window       = '0;
            clean_run    = 0;
            grand_total  = '0;
            fails        = 0;
            predicted_results.delete();
            for (int j = 0; j < TABLE_DEPTH; j++) tally[j] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KMER_LENGTH) kmer_len = KLEN_W'(i_cfg_data);
                else if (i_cfg_idx == CFG_BOTH_STRANDS) both_strands = i_cfg_data[0];
            end
            // result transfer against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (predicted_results.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                    fails++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("counted", 32'(want.counted), 32'(i_res.counted));
                    compare_field("kmer_code", 32'(want.kmer_code), 32'(i_res.kmer_code));
                    compare_field("total_windows", want.total_windows, i_res.total_windows);
                    compare_field("count_value", want.count_value, i_res.count_value);
                end
            end
            // input transfer
            if (i_kmer.valid && i_kmer.ready)
                predicted_results.push_back(count_item(t_kind'(i_kmer.kind), i_kmer.base,
                                                       i_kmer.query_index));
        end
        o_pending    <= predicted_results.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the k-mer counter. Drives bases, sequence ends and
// count queries through the valid/ready channel under several lengths and
// strand modes, with sender gaps, receiver stalls and a long output hold-off;
// the checker beside the block predicts and compares every result.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import kcf_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int NUM_PHASES      = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_req = 0;
    int                    hold_left = 0;
    logic [QIDX_W-1:0]     query_mask = 16'hFF;

    // per phase: length, strand mode, sender idle and receiver stall percentages
    logic [KLEN_W-1:0] phase_len   [NUM_PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5};
    logic              phase_both  [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int                phase_idle  [NUM_PHASES] = '{0, 72, 0, 25, 0, 0};
    int                phase_stall [NUM_PHASES] = '{0, 0, 72, 25, 0, 0};

    kcf_in_if  kmer_ch ();
    kcf_out_if res_ch ();

    kmer_counter_n_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kmer     (kmer_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    kmer_count_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kmer       (kmer_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when requested
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (recv_stall_pct == 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // offer one item, with random gaps, and wait for its transfer
    task automatic send_item(input t_kind kind, input logic [BASE_W-1:0] base,
                             input logic [QIDX_W-1:0] query);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            kmer_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        kmer_ch.valid       <= 1'b1;
        kmer_ch.kind        <= kind;
        kmer_ch.base        <= base;
        kmer_ch.query_index <= query;
        @(posedge i_clk);
        while (!kmer_ch.ready) @(posedge i_clk);
    endtask

    // mostly clean bases, some N letters, sequence ends and count queries
    task automatic send_random();
        int unsigned       pick;
        t_kind             kind;
        logic [BASE_W-1:0] base;
        logic [QIDX_W-1:0] query;
        pick  = $urandom_range(99, 0);
        kind  = KIND_BASE;
        base  = BASE_W'($urandom_range(3, 0));
        query = QIDX_W'($urandom());
        if (pick < 68) begin
        end else if (pick < 78) begin
            base = BASE_W'($urandom_range(7, 4));
        end else if (pick < 83) begin
            kind = KIND_END;
            base = BASE_W'($urandom_range(7, 0));
        end else if (pick < 97) begin
            kind = KIND_QUERY;
            base = BASE_W'($urandom_range(7, 0));
            // most queries land on codes the current length can reach
            if (pick < 92) query = query & query_mask;
        end else begin
            kind = KIND_NONE;
            base = BASE_W'($urandom_range(7, 0));
        end
        send_item(kind, base, query);
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_idle();
        kmer_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write both registers; only called while the block is idle
    task automatic set_config(input logic [KLEN_W-1:0] len, input logic both);
        int unsigned k;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_KMER_LENGTH;
        cfg_data <= CFG_DATA_W'(len);
        @(posedge i_clk);
        cfg_idx  <= CFG_BOTH_STRANDS;
        cfg_data <= {3'($urandom_range(7, 0)), both};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        k = (len == '0) ? 1 : ((int'(len) > MAX_KMER) ? MAX_KMER : len);
        query_mask = QIDX_W'((32'd1 << (2 * k)) - 1);
    endtask

    // main sequence
    initial begin
        i_rst_n             <= 1'b0;
        kmer_ch.valid       <= 1'b0;
        kmer_ch.kind        <= KIND_BASE;
        kmer_ch.base        <= '0;
        kmer_ch.query_index <= '0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_KMER_LENGTH;
        cfg_data            <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(KMER_LENGTH_RST, 1'b1);

        // directed: length 4, both strands
        send_item(KIND_QUERY, 3'd0, 16'h0000);   // empty table
        send_item(KIND_BASE, 3'd0, 16'h0000);    // A
        send_item(KIND_BASE, 3'd1, 16'h0000);    // C
        send_item(KIND_BASE, 3'd2, 16'h0000);    // G
        send_item(KIND_BASE, 3'd3, 16'h0000);    // T: ACGT is its own reverse complement
        send_item(KIND_QUERY, 3'd0, 16'h001B);   // counted twice
        send_item(KIND_BASE, 3'd2, 16'h0000);    // CGTG and its reverse complement
        send_item(KIND_BASE, 3'd4, 16'h0000);    // N
        send_item(KIND_BASE, 3'd7, 16'h0000);    // other letter
        send_item(KIND_BASE, 3'd0, 16'h0000);
        send_item(KIND_BASE, 3'd1, 16'h0000);
        send_item(KIND_BASE, 3'd2, 16'h0000);    // run still short
        send_item(KIND_BASE, 3'd5, 16'h0000);    // other letter breaks the run
        send_item(KIND_BASE, 3'd3, 16'h0000);
        send_item(KIND_END, 3'd3, 16'hFFFF);     // sequence end clears window
        send_item(KIND_BASE, 3'd3, 16'h0000);
        send_item(KIND_BASE, 3'd3, 16'h0000);
        send_item(KIND_BASE, 3'd3, 16'h0000);
        send_item(KIND_BASE, 3'd3, 16'hFFFF);    // TTTT, reverse AAAA
        send_item(KIND_NONE, 3'd7, 16'hFFFF);    // unused kind
        send_item(KIND_BASE, 3'd6, 16'h0000);
        send_item(KIND_QUERY, 3'd7, 16'h00FF);
        send_item(KIND_QUERY, 3'd0, 16'h0000);
        send_item(KIND_QUERY, 3'd0, 16'hFFFF);
        wait_idle();

        // random phases over lengths, strand modes and flow patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(phase_len[p], phase_both[p]);
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            // output held off while items keep coming, so the input stalls
            if (p == 4) hold_req = HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender pause in the middle of a phase
                if (p == 1 && n == 30) wait_idle();
                send_random();
            end
            wait_idle();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/kcf_pkg.sv
sv/kcf_if.sv
sv/kcf_ram.sv
sv/kcf_seq.sv
sv/kcf_rmw.sv
sv/kcf_fifo.sv
sv/kmer_counter_n_filter.sv
tb/kmer_count_checker.sv
tb/testbench.sv
